>>> sv/prbf_pkg.sv
package prbf_pkg;

  // Longest record that is still accepted, in bytes.
  localparam int unsigned MAX_RECORD_BYTES = 65536;
  // Width of a record length or byte offset; it must hold MAX_RECORD_BYTES itself.
  localparam int unsigned LEN_W = $clog2(MAX_RECORD_BYTES + 1);
  // Address width of the header byte map, one bit per record offset.
  localparam int unsigned MAP_AW = $clog2(MAX_RECORD_BYTES);
  localparam int unsigned MAP_DEPTH = 1 << MAP_AW;

  // Result queue between the classifier and the output port.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [31:0] MAGIC_WORD = 32'h3152_4150;
  localparam logic [31:0] MIN_META_LEN = 32'd9;
  // A footer match needs at least this many record bytes.
  localparam int unsigned MIN_FOOTER_N = 12;

  typedef enum logic [1:0] {
    KIND_RECORD    = 2'd0,
    KIND_BAD_MAGIC = 2'd1,
    KIND_NO_FOOTER = 2'd2,
    KIND_TOO_LONG  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [LEN_W-1:0] length;
  } res_t;

  // True for the Thrift field headers that may open the file metadata.
  function automatic logic is_thrift_header(input logic [7:0] b);
    return (b == 8'h15) || (b == 8'h29) || (b == 8'h36) || (b == 8'h49) ||
           (b == 8'h59) || (b == 8'h68) || (b == 8'h79);
  endfunction

endpackage

>>> sv/prbf_front.sv
module prbf_front
  import prbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_final_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output logic       res_push_o,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_DROP = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [LEN_W-1:0] offset_q, offset_d;
  logic [7:0]       recent_q [9];

  // Header byte map and the read pipeline that follows it.
  logic             map_q [MAP_DEPTH];
  logic             map_rd_q;
  logic [2:0]       map_pipe_q;

  logic             accept;
  logic             step;
  logic [7:0]       win [9];
  logic [LEN_W-1:0] n;
  logic             magic_ok;
  logic [31:0]      meta_len;
  logic [31:0]      spec_len;
  logic [MAP_AW-1:0] rd_addr;
  logic             fits;
  logic             footer;
  logic             active;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign active     = (phase_q == PH_IDLE) || (phase_q == PH_BODY);
  assign step       = accept && active;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      win[i] = recent_q[i+1];
    end
    win[8] = in_byte_i;
  end

  assign n        = offset_q + LEN_W'(1);
  assign magic_ok = {win[8], win[7], win[6], win[5]} == MAGIC_WORD;
  assign meta_len = {win[4], win[3], win[2], win[1]};
  assign fits     = ({1'b0, meta_len} + 33'd12) <= {{(33-LEN_W){1'b0}}, n};

  // The length field of a footer ends four bytes before its closing magic, so the
  // map bit it points at is fetched then and carried along with the next bytes.
  assign spec_len = {in_byte_i, recent_q[8], recent_q[7], recent_q[6]};
  assign rd_addr  = n[MAP_AW-1:0] - MAP_AW'(4) - spec_len[MAP_AW-1:0];

  assign footer = (n >= LEN_W'(MIN_FOOTER_N)) && magic_ok && (meta_len >= MIN_META_LEN) &&
                  fits && (win[0] == 8'h00) && map_pipe_q[2];

  always_ff @(posedge clk_i) begin
    if (step) begin
      map_q[offset_q[MAP_AW-1:0]] <= is_thrift_header(in_byte_i);
      map_rd_q <= map_q[rd_addr];
      map_pipe_q <= {map_pipe_q[1:0], map_rd_q};
    end
  end

  always_comb begin
    phase_d    = phase_q;
    offset_d   = offset_q;
    res_push_o = 1'b0;
    res_o.kind   = KIND_RECORD;
    res_o.length = '0;
    if (accept) begin
      if (!active) begin
        if (in_final_i) begin
          phase_d  = PH_IDLE;
          offset_d = '0;
        end
      end else begin
        phase_d  = PH_BODY;
        offset_d = n;
        priority if ((n == LEN_W'(4)) && !magic_ok) begin
          res_push_o = 1'b1;
          res_o.kind = KIND_BAD_MAGIC;
          phase_d    = in_final_i ? PH_IDLE : PH_DROP;
          offset_d   = '0;
        end else if (footer) begin
          res_push_o   = 1'b1;
          res_o.kind   = KIND_RECORD;
          res_o.length = n;
          phase_d      = PH_IDLE;
          offset_d     = '0;
        end else if (n >= LEN_W'(MAX_RECORD_BYTES)) begin
          res_push_o = 1'b1;
          res_o.kind = KIND_TOO_LONG;
          phase_d    = in_final_i ? PH_IDLE : PH_DROP;
          offset_d   = '0;
        end else if (in_final_i) begin
          res_push_o = 1'b1;
          res_o.kind = (n < LEN_W'(4)) ? KIND_BAD_MAGIC : KIND_NO_FOOTER;
          phase_d    = PH_IDLE;
          offset_d   = '0;
        end else begin
          res_push_o = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      offset_q <= '0;
      for (int i = 0; i < 9; i++) begin
        recent_q[i] <= 8'h00;
      end
    end else begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      if (step) begin
        for (int i = 0; i < 9; i++) begin
          recent_q[i] <= win[i];
        end
      end
    end
  end

endmodule

>>> sv/prbf_queue.sv
module prbf_queue
  import prbf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t item_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output res_t item_o
);

  res_t           slot_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = count_q == (QAW+1)'(QDEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (QAW+1)'(1);
        2'b01:   count_q <= count_q - (QAW+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> sv/parquet_record_boundary_finder.sv
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[7:0] tlast   one stream byte, tlast = final byte
// m_axis    out        tvalid tready tdata[23:0] tuser  record length, result kind
//
// One byte is taken every clock cycle. The result a byte causes is queued at the
// edge that takes the byte and shows on m_axis in the next cycle at the earliest.
// s_axis_tready_o drops only while the four-word result queue is full.
// The header byte map has one write and one read port, both used by every byte that is not discarded.
// Reset needs no clearing pass: a map bit is only consulted inside the record
// that wrote it.
module parquet_record_boundary_finder
  import prbf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [7:0] data_byte.
  input  logic [7:0]  s_axis_tdata_i,
  // tlast: final_byte, the last byte of an input stream; parsing restarts after it.
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: [16:0] record_length, [23:17] zero.
  output logic [23:0] m_axis_tdata_o,
  // tuser: [1:0] result_kind.
  output logic [1:0]  m_axis_tuser_o
);

  // The front end follows the record framing and the footer test; each result it
  // produces goes into a short queue, which the output side drains on its own.
  logic q_full;
  logic res_push;
  res_t res;
  res_t out_item;

  prbf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_final_i (s_axis_tlast_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .res_push_o (res_push),
    .res_o      (res)
  );

  prbf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res),
    .full_o  (q_full),
    .pop_i   (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .item_o  (out_item)
  );

  // Error words carry a zero length, so the length field passes through as is.
  assign m_axis_tdata_o = {{(24-LEN_W){1'b0}}, out_item.length};
  assign m_axis_tuser_o = out_item.kind;

endmodule

>>> sv/prbf_checker.sv
module prbf_checker
  import prbf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A word that is offered stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word withdrawn before it was taken");

  // A found record holds at least a header, a minimal footer and its metadata.
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_RECORD) |->
      (m_axis_tdata_o[16:0] >= 17'd21) && (m_axis_tdata_o[16:0] <= 17'd65536) &&
      (m_axis_tdata_o[23:17] == 7'd0))
    else $error("record length out of range");

  // Error words carry no length.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != KIND_RECORD) |-> (m_axis_tdata_o == 24'd0))
    else $error("error word with nonzero length");

  // Results only appear after a byte was taken in.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("result word without a byte taken");

endmodule

bind parquet_record_boundary_finder prbf_checker u_prbf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

>>> bench/parquet_record_boundary_finder_tb.sv
module parquet_record_boundary_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prbf_pkg::*;

  // A quiet stretch this long, with no word moving on either side, means the
  // block has hung. Even the slowest phase (86 percent idle on one side) stays
  // well below it.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles allowed after the last expected result for anything stray to show.
  localparam int unsigned DRAIN_CYCLES = 20;

  // Phase of the record parser, tracked by the scoreboard's own model.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_BODY    = 2'd1,
    PH_DISCARD = 2'd2
  } parse_phase_e;

  // Ways a generated record may be damaged on purpose.
  typedef enum int {
    FLAW_NONE,
    FLAW_HEAD_MAGIC,
    FLAW_META_HEADER,
    FLAW_STOP_BYTE,
    FLAW_LENGTH,
    FLAW_TAIL_MAGIC,
    FLAW_TRUNCATE
  } record_flaw_e;

  // The scoreboard keeps its own copy of the parser state: the offset into the
  // current record, a nine-byte window of recent bytes and a bit per offset that
  // says whether the byte there could open the file metadata. From each accepted
  // byte it works out whether a result is due, and queues it for the checker.
  class boundary_scoreboard;
    parse_phase_e     phase;
    int unsigned      rec_offset;
    logic [7:0]       recent_win [9];
    bit               header_map [MAP_DEPTH];
    res_t             pending_results [$];
    int unsigned      results_expected;
    int unsigned      errors;

    function new();
      phase = PH_IDLE;
      rec_offset = 0;
      results_expected = 0;
      errors = 0;
      foreach (recent_win[i]) recent_win[i] = 8'h00;
      foreach (header_map[i]) header_map[i] = 1'b0;
    endfunction

    // The seven Thrift field headers that may open the file metadata.
    static function logic [7:0] thrift_code(int unsigned idx);
      case (idx)
        0: return 8'h15;
        1: return 8'h29;
        2: return 8'h36;
        3: return 8'h49;
        4: return 8'h59;
        5: return 8'h68;
        default: return 8'h79;
      endcase
    endfunction

    static function bit is_meta_header(logic [7:0] b);
      for (int i = 0; i < 7; i++) begin
        if (b == thrift_code(i)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit tail_is_magic();
      return {recent_win[8], recent_win[7], recent_win[6], recent_win[5]} == MAGIC_WORD;
    endfunction

    // A footer closes the record at byte count n when the window holds a zero
    // stop byte, a plausible metadata length and the closing magic, and the
    // metadata start that the length points at held a Thrift header.
    function bit footer_closes(int unsigned n);
      logic [31:0]     meta_len;
      longint unsigned room;
      if (n < MIN_FOOTER_N || !tail_is_magic()) return 1'b0;
      meta_len = {recent_win[4], recent_win[3], recent_win[2], recent_win[1]};
      if (meta_len < MIN_META_LEN) return 1'b0;
      room = longint'(n) - 8;
      if (64'd4 + longint'(meta_len) > room) return 1'b0;
      if (recent_win[0] != 8'h00) return 1'b0;
      return header_map[room - meta_len];
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      int unsigned n;
      res_t        r;
      bit          due;
      // Discarding after an error: drop bytes until the final one.
      if (phase >= PH_DISCARD) begin
        if (fin) begin
          phase = PH_IDLE;
          rec_offset = 0;
        end
        return;
      end
      for (int i = 0; i < 8; i++) recent_win[i] = recent_win[i + 1];
      recent_win[8] = b;
      header_map[rec_offset] = is_meta_header(b);
      n = rec_offset + 1;
      rec_offset = n;
      phase = PH_BODY;
      due = 1'b1;
      r.length = '0;
      if (n == 4 && !tail_is_magic()) begin
        r.kind = KIND_BAD_MAGIC;
      end else if (footer_closes(n)) begin
        r.kind = KIND_RECORD;
        r.length = n[LEN_W-1:0];
      end else if (n >= MAX_RECORD_BYTES) begin
        r.kind = KIND_TOO_LONG;
      end else if (fin) begin
        r.kind = (n < 4) ? KIND_BAD_MAGIC : KIND_NO_FOOTER;
      end else begin
        due = 1'b0;
      end
      if (due) begin
        pending_results.push_back(r);
        results_expected++;
        if (r.kind == KIND_RECORD || fin) begin
          phase = PH_IDLE;
          rec_offset = 0;
        end else begin
          phase = PH_DISCARD;
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [1:0] kind, logic [23:0] data);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending: kind %0d data 0x%06h",
                                  kind, data));
        return;
      end
      want = pending_results.pop_front();
      if (kind != want.kind) begin
        report_mismatch($sformatf("result kind %0d, wanted %0d", kind, want.kind));
      end
      if (data != 24'(want.length)) begin
        report_mismatch($sformatf("record length word 0x%06h, wanted 0x%06h",
                                  data, 24'(want.length)));
      end
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata: [7:0] data_byte.
  logic [7:0]  s_axis_tdata_i = 8'h00;
  // tlast: final_byte.
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata: [16:0] record_length, [23:17] zero.
  logic [23:0] m_axis_tdata_o;
  // tuser: [1:0] result_kind.
  logic [1:0]  m_axis_tuser_o;

  boundary_scoreboard sb;
  int unsigned        bytes_sent = 0;
  int unsigned        quiet_cycles = 0;
  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned        src_idle_pct = 0;
  int unsigned        sink_stall_pct = 0;

  parquet_record_boundary_finder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // The receiver decides afresh at every edge whether it takes a word in the
  // coming cycle, so stalls land on every phase of the block's work.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Output monitor and hang detector. Both sample at the rising edge, before
  // the block's own registers update, so they see the values of the cycle that
  // just ended.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[%0t] no word moved for %0d cycles", $realtime, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one byte, idling first at the current sender rate, and holds it until
  // the block takes it. Each edge sees exactly one update of tvalid, so a byte
  // that follows another without a gap keeps tvalid high throughout.
  task automatic send_byte(logic [7:0] b, logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_byte(b, fin);
    bytes_sent++;
  endtask

  // Builds one file: opening magic, body, metadata that opens with a Thrift
  // header and closes with a zero stop byte, the little-endian metadata length
  // and the closing magic. A flaw breaks one of those rules; a flawed record
  // always ends on a final byte so that the parser gets back in step.
  task automatic send_record(int unsigned body_len, int unsigned meta_len,
                             record_flaw_e flaw, bit fin_at_end);
    logic [7:0]  rec [$];
    logic [31:0] len_field;
    logic [7:0]  b;
    int unsigned pos;
    int unsigned stop;
    bit          close_fin;
    for (int i = 0; i < 4; i++) rec.push_back(MAGIC_WORD[8*i +: 8]);
    if (flaw == FLAW_HEAD_MAGIC) begin
      pos = $urandom_range(3);
      rec[pos] = rec[pos] ^ (8'h01 << $urandom_range(7));
    end
    repeat (body_len) rec.push_back(8'($urandom));
    if (flaw == FLAW_META_HEADER) begin
      do b = 8'($urandom); while (boundary_scoreboard::is_meta_header(b));
    end else begin
      b = boundary_scoreboard::thrift_code($urandom_range(6));
    end
    rec.push_back(b);
    repeat (meta_len - 2) rec.push_back(8'($urandom));
    rec.push_back((flaw == FLAW_STOP_BYTE) ? 8'($urandom_range(255, 1)) : 8'h00);
    len_field = meta_len;
    if (flaw == FLAW_LENGTH) begin
      case ($urandom_range(2))
        0: len_field = $urandom_range(8);
        1: len_field = meta_len + body_len + 1 + $urandom_range(3);
        default: len_field = $urandom;
      endcase
    end
    for (int i = 0; i < 4; i++) rec.push_back(len_field[8*i +: 8]);
    for (int i = 0; i < 4; i++) rec.push_back(MAGIC_WORD[8*i +: 8]);
    if (flaw == FLAW_TAIL_MAGIC) begin
      pos = rec.size() - 1 - $urandom_range(3);
      rec[pos] = rec[pos] ^ (8'h01 << $urandom_range(7));
    end
    stop = rec.size();
    if (flaw == FLAW_TRUNCATE) stop = $urandom_range(rec.size() - 1, 1);
    close_fin = fin_at_end || (flaw != FLAW_NONE);
    for (int unsigned i = 0; i < stop; i++) begin
      send_byte(rec[i], close_fin && (i == stop - 1));
    end
  endtask

  // Mostly well-formed files with random content, since only those end in a found
  // record; the rest are damaged files and short bursts of noise. Runs
  // until both enough bytes and enough results have gone by.
  task automatic run_random(int unsigned min_bytes, int unsigned min_results);
    int unsigned bytes_start;
    int unsigned results_start;
    int unsigned pick;
    int unsigned noise_len;
    bytes_start = bytes_sent;
    results_start = sb.results_expected;
    while (bytes_sent - bytes_start < min_bytes ||
           sb.results_expected - results_start < min_results) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_record($urandom_range(6), $urandom_range(14, 9), FLAW_NONE,
                    $urandom_range(3) == 0);
      end else if (pick < 88) begin
        send_record($urandom_range(6), $urandom_range(14, 9),
                    record_flaw_e'($urandom_range(FLAW_TRUNCATE, FLAW_HEAD_MAGIC)), 1'b1);
      end else begin
        noise_len = $urandom_range(12, 1);
        for (int unsigned i = 0; i < noise_len; i++) begin
          send_byte(8'($urandom), i == noise_len - 1);
        end
      end
    end
  endtask

  // The sender holds back until every expected result has come out.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with no idling on either side.
    // Wrong opening magic, then two discarded bytes ending in the final byte.
    send_byte(8'h50, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h52, 1'b0);
    send_byte(8'h32, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    // Input ends after two bytes of a new record.
    send_byte(8'h50, 1'b0);
    send_byte(8'h41, 1'b1);
    // The shortest file that can pass: nine bytes of metadata, no body.
    send_record(0, 9, FLAW_NONE, 1'b0);
    // A bad opening magic that arrives on the final byte itself.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // Random part in four idling phases, draining in between.
    run_random(120, 6);
    drain_results();
    src_idle_pct = 86;
    sink_stall_pct = 0;
    run_random(120, 6);
    drain_results();
    src_idle_pct = 0;
    sink_stall_pct = 86;
    run_random(120, 6);
    drain_results();
    src_idle_pct = 8;
    sink_stall_pct = 8;
    run_random(120, 6);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
